@@ design/decimal_ascii_status_formatter_assert.svh @@
// Assertion macros used by the formatter top module.
`ifndef DECIMAL_ASCII_STATUS_FORMATTER_ASSERT_SVH
`define DECIMAL_ASCII_STATUS_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DASF_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dasf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DASF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dasf assertion failed");

`endif

@@ design/dasf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dasf_pkg;

  // ASCII code of the digit zero.
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // Index of the final suffix character for each flag value.
  localparam logic [1:0] SFX_LAST_ON  = 2'd2;
  localparam logic [1:0] SFX_LAST_OFF = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [31:0] light_level;
    logic        light_is_on;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] character;
    logic       last_character;
  } out_beat_t;

  // Converter control and status.
  typedef struct packed {
    logic start;
  } conv_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_sts_t;

  // Emitter control and status.
  typedef struct packed {
    logic load;
    logic light_is_on;
  } emit_ctl_t;

  typedef struct packed {
    logic busy;
  } emit_sts_t;

  // Suffix character: "_on" when the flag is set, "_off" otherwise.
  function automatic logic [7:0] suffix_char(input logic on, input logic [1:0] idx);
    logic [7:0] ch;
    ch = 8'h5f;
    case (idx)
      2'd0: ch = 8'h5f;
      2'd1: ch = 8'h6f;
      2'd2: ch = on ? 8'h6e : 8'h66;
      default: ch = 8'h66;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ design/decimal_ascii_status_formatter.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_ascii_status_formatter_assert.svh"

// Prints a light-level reading as ASCII decimal, most significant digit first
// with no leading zeros, followed by "_on" or "_off", one character per output
// beat with the final character marked. Only the low LEVEL_WIDTH bits of the
// reading are used. One reading is handled at a time: the bit-serial
// shift-and-add-three loop converts it into as many decimal digits as
// LEVEL_WIDTH bits can hold (10 for 32 bits), then the digit shifter drops
// the leading zeros and sends the digits, then the suffix. The next reading is
// taken once the emitter and then the sequencer state have returned to idle
// after the final character enters the output register.
module decimal_ascii_status_formatter #(
  parameter int LEVEL_WIDTH = 32
) (
  input  wire  logic                 clk_i,
  input  wire  logic                 rst_ni,
  input  wire  logic                 in_valid_i,
  output       logic                 in_stall_o,
  input  wire  dasf_pkg::in_beat_t   in_data_i,
  output       logic                 out_valid_o,
  input  wire  logic                 out_stall_i,
  output       dasf_pkg::out_beat_t  out_data_o
);

  localparam int DIGITS = (LEVEL_WIDTH * 1233) / 4096 + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                on_q, on_d;
  logic                in_accept;
  dasf_pkg::conv_ctl_t conv_ctl;
  dasf_pkg::conv_sts_t conv_sts;
  dasf_pkg::emit_ctl_t emit_ctl;
  dasf_pkg::emit_sts_t emit_sts;
  logic [DIGITS*4-1:0] bcd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Item sequencing: convert, then emit.
  always_comb begin
    state_d = state_q;
    on_d    = on_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          on_d    = in_data_i.light_is_on;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_sts.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_sts.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    on_q <= on_d;
  end

  assign conv_ctl.start       = in_accept;
  assign emit_ctl.load        = (state_q == ST_CONV) && conv_sts.done;
  assign emit_ctl.light_is_on = on_q;

  dasf_bin2bcd #(
    .LEVEL_WIDTH(LEVEL_WIDTH),
    .DIGITS     (DIGITS)
  ) u_bin2bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (conv_ctl),
    .level_i(in_data_i.light_level[LEVEL_WIDTH-1:0]),
    .sts_o  (conv_sts),
    .bcd_o  (bcd)
  );

  dasf_emit #(
    .DIGITS(DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (emit_ctl),
    .bcd_i      (bcd),
    .sts_o      (emit_sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // An accepted beat always starts a conversion.
  `DASF_ASSERT_NEXT(a_accept_starts_conv, clk_i, rst_ni, in_accept, conv_sts.busy)
  // A finished conversion only shows up while the sequencer waits for it.
  `DASF_ASSERT_SAME(a_done_in_conv, clk_i, rst_ni, conv_sts.done, state_q == ST_CONV)
  // Nothing is in flight while new input is taken.
  `DASF_ASSERT_SAME(a_idle_quiet, clk_i, rst_ni, state_q == ST_IDLE,
                    !conv_sts.busy && !emit_sts.busy)

endmodule

`default_nettype wire

@@ design/dasf_bin2bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial binary to BCD converter (shift and add three).
module dasf_bin2bcd #(
  parameter int LEVEL_WIDTH = 32,
  parameter int DIGITS      = 10
) (
  input  wire  logic                    clk_i,
  input  wire  logic                    rst_ni,
  input  wire  dasf_pkg::conv_ctl_t     ctl_i,
  input  wire  logic [LEVEL_WIDTH-1:0]  level_i,
  output       dasf_pkg::conv_sts_t     sts_o,
  output       logic [DIGITS*4-1:0]     bcd_o
);

  localparam int CW = $clog2(LEVEL_WIDTH + 1);

  logic [LEVEL_WIDTH-1:0] bin_q, bin_d;
  logic [DIGITS*4-1:0]    bcd_q, bcd_d;
  logic [DIGITS*4-1:0]    adj;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  // Each digit of five or more gets three added before the shift.
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    adj = bcd_q;
    for (int k = 0; k < DIGITS; k++) begin
      dig = bcd_q[4*k +: 4];
      adj[4*k +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // One binary bit moves into the BCD register per cycle while a conversion runs.
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      bin_d  = level_i;
      bcd_d  = '0;
      cnt_d  = CW'(LEVEL_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[DIGITS*4-2:0], bin_q[LEVEL_WIDTH-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bcd_o      = bcd_q;

endmodule

`default_nettype wire

@@ design/dasf_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character emitter: skips leading zeros, shifts out digits, then the suffix.
module dasf_emit #(
  parameter int DIGITS = 10
) (
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  dasf_pkg::emit_ctl_t   ctl_i,
  input  wire  logic [DIGITS*4-1:0]   bcd_i,
  output       dasf_pkg::emit_sts_t   sts_o,
  output       logic                  out_valid_o,
  input  wire  logic                  out_stall_i,
  output       dasf_pkg::out_beat_t   out_data_o
);

  localparam int LW = $clog2(DIGITS + 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SKIP = 2'd1;
  localparam logic [1:0] M_DIG  = 2'd2;
  localparam logic [1:0] M_SFX  = 2'd3;

  logic [1:0]          mode_q, mode_d;
  logic [DIGITS*4-1:0] dig_q, dig_d;
  logic [LW-1:0]       left_q, left_d;
  logic [1:0]          sfx_q, sfx_d;
  logic                on_q, on_d;
  logic                vld_q, vld_d;
  dasf_pkg::out_beat_t beat_q, beat_d;
  logic                can_load;
  logic [3:0]          top_dig;
  logic                sfx_last;

  assign can_load = !vld_q || !out_stall_i;
  assign top_dig  = dig_q[DIGITS*4-1 -: 4];
  assign sfx_last = (sfx_q == (on_q ? dasf_pkg::SFX_LAST_ON : dasf_pkg::SFX_LAST_OFF));

  // Sequencer and output register.
  always_comb begin
    mode_d = mode_q;
    dig_d  = dig_q;
    left_d = left_q;
    sfx_d  = sfx_q;
    on_d   = on_q;
    vld_d  = vld_q;
    beat_d = beat_q;
    if (can_load) begin
      vld_d = 1'b0;
    end
    unique case (mode_q)
      M_IDLE: begin
        if (ctl_i.load) begin
          dig_d  = bcd_i;
          left_d = LW'(DIGITS);
          on_d   = ctl_i.light_is_on;
          mode_d = M_SKIP;
        end
      end
      M_SKIP: begin
        // Drop leading zeros, keeping at least one digit.
        if (top_dig == 4'd0 && left_q > LW'(1)) begin
          dig_d  = dig_q << 4;
          left_d = left_q - LW'(1);
        end else begin
          mode_d = M_DIG;
        end
      end
      M_DIG: begin
        if (can_load) begin
          vld_d                 = 1'b1;
          beat_d.character      = dasf_pkg::CHAR_ZERO + {4'd0, top_dig};
          beat_d.last_character = 1'b0;
          dig_d                 = dig_q << 4;
          left_d                = left_q - LW'(1);
          if (left_q == LW'(1)) begin
            sfx_d  = 2'd0;
            mode_d = M_SFX;
          end
        end
      end
      M_SFX: begin
        if (can_load) begin
          vld_d                 = 1'b1;
          beat_d.character      = dasf_pkg::suffix_char(on_q, sfx_q);
          beat_d.last_character = sfx_last;
          sfx_d                 = sfx_q + 2'd1;
          if (sfx_last) begin
            mode_d = M_IDLE;
          end
        end
      end
      default: mode_d = M_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      vld_q  <= 1'b0;
      left_q <= '0;
      sfx_q  <= '0;
    end else begin
      mode_q <= mode_d;
      vld_q  <= vld_d;
      left_q <= left_d;
      sfx_q  <= sfx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    on_q   <= on_d;
    beat_q <= beat_d;
  end

  assign sts_o.busy  = (mode_q != M_IDLE);
  assign out_valid_o = vld_q;
  assign out_data_o  = beat_q;

endmodule

`default_nettype wire
